FILE: src/utf8_validate_lead_marks_core_assert.svh
// assertion macros for the utf8 lead-mark validator
// depends on nothing; used by the top level only
`ifndef UTF8_VALIDATE_LEAD_MARKS_CORE_ASSERT_SVH
`define UTF8_VALIDATE_LEAD_MARKS_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UTF8VL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("utf8vl assertion failed");

// next-cycle implication, disabled while in reset
`define UTF8VL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("utf8vl assertion failed");

`endif

FILE: src/utf8vl_pkg.sv
// shared types, constants and lookup tables of the utf8 lead-mark validator
// depends on nothing
package utf8vl_pkg;

	localparam int LANES = 8;
	localparam int LIMIT = (LANES < 8) ? LANES : 8;
	localparam int CNT_W = $clog2(LIMIT + 1);
	localparam int EXT_N = LIMIT + 3;
	localparam int HIST_W = 24;
	localparam int MARK_W = 8;

	typedef logic [7:0] byte_t;

	// byte class thresholds
	localparam byte_t LEAD2_MIN = 8'hC0;
	localparam byte_t THIRD_MIN = 8'hE0;
	localparam byte_t FOURTH_MIN = 8'hF0;
	localparam byte_t MUST_BIT = 8'h80;
	localparam logic [1:0] CONT_TAG = 2'b10;

	// error classes
	localparam byte_t E_SHORT = 8'h01;
	localparam byte_t E_LONG = 8'h02;
	localparam byte_t E_OVL3 = 8'h04;
	localparam byte_t E_LARGE = 8'h08;
	localparam byte_t E_SURR = 8'h10;
	localparam byte_t E_OVL2 = 8'h20;
	localparam byte_t E_L1000 = 8'h40;
	localparam byte_t E_OVL4 = 8'h40;
	localparam byte_t E_TWOC = 8'h80;
	localparam byte_t E_CARRY = E_SHORT | E_LONG | E_TWOC;

	localparam byte_t LEAD_HI_TAB [16] = '{
		E_LONG, E_LONG, E_LONG, E_LONG, E_LONG, E_LONG, E_LONG, E_LONG,
		E_TWOC, E_TWOC, E_TWOC, E_TWOC,
		E_SHORT | E_OVL2,
		E_SHORT,
		E_SHORT | E_OVL3 | E_SURR,
		E_SHORT | E_LARGE | E_L1000 | E_OVL4
	};

	localparam byte_t LEAD_LO_TAB [16] = '{
		E_CARRY | E_OVL3 | E_OVL2 | E_OVL4,
		E_CARRY | E_OVL2,
		E_CARRY,
		E_CARRY,
		E_CARRY | E_LARGE,
		E_CARRY | E_LARGE | E_L1000, E_CARRY | E_LARGE | E_L1000,
		E_CARRY | E_LARGE | E_L1000, E_CARRY | E_LARGE | E_L1000,
		E_CARRY | E_LARGE | E_L1000, E_CARRY | E_LARGE | E_L1000,
		E_CARRY | E_LARGE | E_L1000, E_CARRY | E_LARGE | E_L1000,
		E_CARRY | E_LARGE | E_L1000 | E_SURR,
		E_CARRY | E_LARGE | E_L1000, E_CARRY | E_LARGE | E_L1000
	};

	localparam byte_t NEXT_HI_TAB [16] = '{
		E_SHORT, E_SHORT, E_SHORT, E_SHORT, E_SHORT, E_SHORT, E_SHORT, E_SHORT,
		E_LONG | E_OVL2 | E_TWOC | E_OVL3 | E_L1000 | E_OVL4,
		E_LONG | E_OVL2 | E_TWOC | E_OVL3 | E_LARGE,
		E_LONG | E_OVL2 | E_TWOC | E_SURR | E_LARGE,
		E_LONG | E_OVL2 | E_TWOC | E_SURR | E_LARGE,
		E_SHORT, E_SHORT, E_SHORT, E_SHORT
	};

	typedef struct packed {
		logic bad;
		logic mark;
	} lane_res_t;

	typedef struct packed {
		logic [MARK_W-1:0] marks;
		logic err;
		logic done;
	} result_t;

endpackage

FILE: src/utf8vl_lane.sv
// one byte lane: lookup4 check of a byte against the three bytes before it
// depends on utf8vl_pkg
module utf8vl_lane (
	input utf8vl_pkg::byte_t cur,
	input utf8vl_pkg::byte_t p1,
	input utf8vl_pkg::byte_t p2,
	input utf8vl_pkg::byte_t p3,
	output utf8vl_pkg::lane_res_t res
);
	import utf8vl_pkg::*;

	byte_t sc;
	byte_t must;

	always_comb begin
		sc = LEAD_HI_TAB[p1[7:4]] & LEAD_LO_TAB[p1[3:0]] & NEXT_HI_TAB[cur[7:4]];
		// third or fourth byte of a sequence expected here
		must = (p2 >= THIRD_MIN || p3 >= FOURTH_MIN) ? MUST_BIT : '0;
		res.bad = |(sc ^ must);
		res.mark = (cur[7:6] != CONT_TAG);
	end

endmodule

FILE: src/utf8vl_merge.sv
// merge stage: masks lanes by count, folds errors, picks next history bytes
// depends on utf8vl_pkg
module utf8vl_merge (
	input utf8vl_pkg::byte_t ext [utf8vl_pkg::EXT_N],
	input utf8vl_pkg::lane_res_t lanes [utf8vl_pkg::LIMIT],
	input logic [utf8vl_pkg::CNT_W-1:0] cnt,
	input logic last,
	input logic err_in,
	output utf8vl_pkg::result_t res,
	output logic [utf8vl_pkg::HIST_W-1:0] hist_next
);
	import utf8vl_pkg::*;

	logic bad_any;
	logic end_bad;
	logic active;

	always_comb begin
		bad_any = 1'b0;
		res.marks = '0;
		for (int k = 0; k < LIMIT; k++) begin
			active = (CNT_W'(k) < cnt);
			bad_any = bad_any | (active & lanes[k].bad);
			res.marks[k] = active & lanes[k].mark;
		end

		// last three consumed bytes, oldest in the top byte
		hist_next = {ext[0], ext[1], ext[2]};
		for (int j = 0; j <= LIMIT; j++) begin
			if (cnt == CNT_W'(j)) begin
				hist_next = {ext[j], ext[j+1], ext[j+2]};
			end
		end

		// unfinished sequence at end of stream
		end_bad = (hist_next[7:0] >= LEAD2_MIN) || (hist_next[15:8] >= THIRD_MIN)
			|| (hist_next[23:16] >= FOURTH_MIN);
		res.err = err_in | bad_any | (last & end_bad);
		res.done = last;
	end

endmodule

FILE: src/utf8_validate_lead_marks_core.sv
// a result is registered in the output register, or in the skid if output stalls
// throughput: one item per cycle unless stalled; all byte lanes check in parallel
// and the history and sticky error update in the same cycle, which is the loop that
// sets the rate; a register plus skid output absorbs one item while output stalls
// reset (arst_n low, asynchronous) clears history, sticky error and both valid flags
module utf8_validate_lead_marks_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] chunk_bytes,
	input logic [3:0] valid_count,
	input logic last_item,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] lead_marks,
	output logic error_seen,
	output logic stream_done
);
	import utf8vl_pkg::*;

`include "utf8_validate_lead_marks_core_assert.svh"

	// stream state carried between items
	logic [HIST_W-1:0] hist_q;
	logic err_q;

	// output register and skid entry
	logic out_valid_q;
	logic skid_valid_q;
	result_t out_res_q;
	result_t skid_res_q;

	logic in_fire;
	logic out_fire;
	logic [CNT_W-1:0] cnt;
	byte_t ext [EXT_N];
	lane_res_t lane_res [LIMIT];
	result_t new_res;
	logic [HIST_W-1:0] hist_next;

	assign in_stall = skid_valid_q;
	assign in_fire = in_valid & ~in_stall;
	assign out_fire = out_valid_q & ~out_stall;

	// counts above the lane count saturate
	assign cnt = (valid_count > LIMIT) ? CNT_W'(LIMIT) : valid_count[CNT_W-1:0];

	// history bytes ahead of the item bytes, oldest first
	always_comb begin
		ext[0] = hist_q[23:16];
		ext[1] = hist_q[15:8];
		ext[2] = hist_q[7:0];
		for (int k = 0; k < LIMIT; k++) begin
			ext[k+3] = chunk_bytes[8*k +: 8];
		end
	end

	// one checker per byte lane
	for (genvar k = 0; k < LIMIT; k++) begin : g_lane
		utf8vl_lane u_lane (
			.cur(ext[k+3]),
			.p1(ext[k+2]),
			.p2(ext[k+1]),
			.p3(ext[k]),
			.res(lane_res[k])
		);
	end

	utf8vl_merge u_merge (
		.ext(ext),
		.lanes(lane_res),
		.cnt(cnt),
		.last(last_item),
		.err_in(err_q),
		.res(new_res),
		.hist_next(hist_next)
	);

	// stream state: a last item puts the block back at stream start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			err_q <= 1'b0;
		end else if (in_fire) begin
			if (last_item) begin
				hist_q <= '0;
				err_q <= 1'b0;
			end else begin
				hist_q <= hist_next;
				err_q <= new_res.err;
			end
		end
	end

	// output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire && skid_valid_q) begin
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_fire && skid_valid_q) begin
			out_res_q <= skid_res_q;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_res_q <= new_res;
			end else begin
				skid_res_q <= new_res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign lead_marks = out_res_q.marks;
	assign error_seen = out_res_q.err;
	assign stream_done = out_res_q.done;

	// skid entry only fills behind a waiting result
	`UTF8VL_ASSERT_NOW(a_skid_behind_main, clk, arst_n, skid_valid_q, out_valid_q)
	// a last item returns the stream state to reset values
	`UTF8VL_ASSERT_NEXT(a_last_clears, clk, arst_n, in_fire && last_item, hist_q == '0 && !err_q)
	// sticky error only drops at end of stream
	`UTF8VL_ASSERT_NEXT(a_err_sticky, clk, arst_n, err_q && !(in_fire && last_item), err_q)

endmodule
